// ===== rtl/cdq_pkg.sv =====
// shared types and codes for the circular deque
// no dependencies
package cdq_pkg;

    localparam int DATA_W = 32;

    localparam logic [1:0] MODE_PUSH_FRONT = 2'd0;
    localparam logic [1:0] MODE_PUSH_REAR  = 2'd1;
    localparam logic [1:0] MODE_POP_FRONT  = 2'd2;
    localparam logic [1:0] MODE_POP_REAR   = 2'd3;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // per-cycle command to every cell of one lane
    typedef struct packed {
        logic shift_up;    // insert at cell 0, everything moves one cell outward
        logic shift_down;  // drop cell 0, everything moves one cell inward
        logic load;        // write the cell whose index equals the fill count
    } cdq_ctrl_t;

endpackage

// ===== rtl/cdq_cell.sv =====
// one storage cell of a deque lane: holds a word, takes it from a neighbor or loads
// depends on cdq_pkg
module cdq_cell #(
    parameter int CNT_W = 5,
    parameter int IDX   = 0
) (
    input  logic                      aclk,
    input  cdq_pkg::cdq_ctrl_t        ctrl,
    input  logic [CNT_W-1:0]          cnt,
    input  logic [cdq_pkg::DATA_W-1:0] din,
    input  logic [cdq_pkg::DATA_W-1:0] lower_word,
    input  logic [cdq_pkg::DATA_W-1:0] upper_word,
    output logic [cdq_pkg::DATA_W-1:0] word
);

    logic [cdq_pkg::DATA_W-1:0] word_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.shift_up) begin
            word_reg <= lower_word;
        end else if (ctrl.shift_down) begin
            word_reg <= upper_word;
        end else if (ctrl.load && (cnt == CNT_W'(IDX))) begin
            word_reg <= din;
        end
    end

    assign word = word_reg;

endmodule

// ===== rtl/cdq_chain.sv =====
// a lane of DEPTH cells; cell 0 holds the word at this lane's end of the deque
// depends on cdq_pkg and cdq_cell
module cdq_chain #(
    parameter int DEPTH = 16,
    parameter int CNT_W = 5
) (
    input  logic                       aclk,
    input  cdq_pkg::cdq_ctrl_t         ctrl,
    input  logic [CNT_W-1:0]           cnt,
    input  logic [cdq_pkg::DATA_W-1:0] din,
    output logic [cdq_pkg::DATA_W-1:0] word0,
    output logic [cdq_pkg::DATA_W-1:0] word1
);

    logic [cdq_pkg::DATA_W-1:0] words [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [cdq_pkg::DATA_W-1:0] lower_w;
        logic [cdq_pkg::DATA_W-1:0] upper_w;

        if (i == 0) begin : g_first
            assign lower_w = din;
        end else begin : g_mid
            assign lower_w = words[i-1];
        end

        // last cell has no upper neighbor; whatever it keeps lies beyond the fill count
        if (i == DEPTH - 1) begin : g_last
            assign upper_w = words[i];
        end else begin : g_inner
            assign upper_w = words[i+1];
        end

        cdq_cell #(
            .CNT_W (CNT_W),
            .IDX   (i)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .cnt        (cnt),
            .din        (din),
            .lower_word (lower_w),
            .upper_word (upper_w),
            .word       (words[i])
        );
    end

    assign word0 = words[0];
    assign word1 = words[1];

endmodule

// ===== rtl/circular_deque.sv =====
// Double-ended queue of up to DEPTH unsigned 32-bit words. Each request on the s_ side
// (s_tuser selects push front, push rear, pop front or pop rear; s_tdata is the word)
// gives one result on the m_ side with the status, the front and rear words after the
// step (0 when empty) and the empty and full flags. The contents live twice, in two
// rows of DEPTH cells that move one cell per cycle: one row ordered from the front,
// one from the rear, so both ends are always read from cell 0 or cell 1. A request is
// taken every cycle while the sink keeps up, its result is registered for the next
// cycle, and a new request is taken while that result waits as long as the sink takes it
// in the same cycle. Depends on cdq_pkg, cdq_chain and cdq_cell.
module circular_deque #(
    parameter int DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // data_value[31:0]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // front_value[31:0], rear_value[63:32]
    output logic [3:0]  m_tuser    // status[1:0], is_empty[2], is_full[3]
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_tvalid_reg;
    logic [1:0]       status_reg, status_next;
    logic [31:0]      front_reg, front_next;
    logic [31:0]      rear_reg, rear_next;
    logic             empty_reg, empty_next;
    logic             full_reg, full_next;

    logic accept, is_push, is_empty_now, is_full_now, do_op;
    cdq_pkg::cdq_ctrl_t front_ctrl, rear_ctrl;
    logic [31:0] f0, f1, r0, r1;

    // no request is taken while in reset
    assign s_tready     = aresetn && (!m_tvalid_reg || m_tready);
    assign accept       = s_tvalid && s_tready;
    assign is_push      = (s_tuser == cdq_pkg::MODE_PUSH_FRONT) ||
                          (s_tuser == cdq_pkg::MODE_PUSH_REAR);
    assign is_empty_now = (cnt_reg == '0);
    assign is_full_now  = (cnt_reg == FULL_CNT);
    assign do_op        = accept && (is_push ? !is_full_now : !is_empty_now);

    // the front lane inserts at cell 0 on push front and loads at the fill count on push rear;
    // the rear lane does the mirror image
    always_comb begin
        front_ctrl = '0;
        rear_ctrl  = '0;
        if (do_op) begin
            case (s_tuser)
                cdq_pkg::MODE_PUSH_FRONT: begin
                    front_ctrl.shift_up = 1'b1;
                    rear_ctrl.load      = 1'b1;
                end
                cdq_pkg::MODE_PUSH_REAR: begin
                    front_ctrl.load     = 1'b1;
                    rear_ctrl.shift_up  = 1'b1;
                end
                cdq_pkg::MODE_POP_FRONT: begin
                    front_ctrl.shift_down = 1'b1;
                end
                cdq_pkg::MODE_POP_REAR: begin
                    rear_ctrl.shift_down = 1'b1;
                end
                default: begin
                    front_ctrl = '0;
                    rear_ctrl  = '0;
                end
            endcase
        end
    end

    cdq_chain #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_front_chain (
        .aclk  (aclk),
        .ctrl  (front_ctrl),
        .cnt   (cnt_reg),
        .din   (s_tdata),
        .word0 (f0),
        .word1 (f1)
    );

    cdq_chain #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_rear_chain (
        .aclk  (aclk),
        .ctrl  (rear_ctrl),
        .cnt   (cnt_reg),
        .din   (s_tdata),
        .word0 (r0),
        .word1 (r1)
    );

    always_comb begin
        cnt_next    = cnt_reg;
        status_next = cdq_pkg::STATUS_DONE;
        front_next  = f0;
        rear_next   = r0;
        if (is_push) begin
            if (is_full_now) begin
                status_next = cdq_pkg::STATUS_FULL;
            end else begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (s_tuser == cdq_pkg::MODE_PUSH_FRONT) begin
                    front_next = s_tdata;
                    rear_next  = is_empty_now ? s_tdata : r0;
                end else begin
                    rear_next  = s_tdata;
                    front_next = is_empty_now ? s_tdata : f0;
                end
            end
        end else begin
            if (is_empty_now) begin
                status_next = cdq_pkg::STATUS_EMPTY;
            end else begin
                cnt_next = cnt_reg - CNT_W'(1);
                if (s_tuser == cdq_pkg::MODE_POP_FRONT) begin
                    front_next = f1;
                end else begin
                    rear_next = r1;
                end
            end
        end
        empty_next = (cnt_next == '0);
        full_next  = (cnt_next == FULL_CNT);
        if (empty_next) begin
            front_next = '0;
            rear_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                cnt_reg      <= cnt_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
            front_reg  <= front_next;
            rear_reg   <= rear_next;
            empty_reg  <= empty_next;
            full_reg   <= full_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {rear_reg, front_reg};
    assign m_tuser  = {full_reg, empty_reg, status_reg};

endmodule
